// ----- src/lkvc_pkg.sv -----
// Package: shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
  } rsp_t;

  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;
  localparam logic [31:0] PutValue  = 32'h0000_0000;
  localparam logic [4:0]  CapReset  = 5'd16;
  localparam logic        RegCap    = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_OUT  = 2'd2
  } state_e;
endpackage
`default_nettype wire

// ----- src/lkvc_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lkvc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                                rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/lru_key_value_cache_top.sv -----
// Top level: LRU key/value cache with APB configuration port.
// Keys, ages and valid bits sit in flip-flop rows so every key is compared in
// parallel; values live in a synchronous RAM. A request is accepted in an idle
// cycle, matched and used to update the rows and the value RAM in the next
// cycle, and its result is presented in the cycle after that, read straight
// from the RAM output. A new request is accepted only once the previous result
// has been taken, so requests never overlap. No clearing pass is needed after
// reset, since only valid slots are read.
`default_nettype none
module lru_key_value_cache_top #(
  parameter int Entries = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lkvc_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lkvc_pkg::rsp_t      out_data_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lkvc_pkg::*;

  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);
  localparam int CmpW = (CntW > 6) ? CntW : 6;

  state_e state_q, state_d;
  logic [4:0]      cap_q;
  logic [31:0]     key_q   [Entries];
  logic [IdxW-1:0] age_q   [Entries];
  logic [Entries-1:0] valid_q;
  logic [CntW-1:0] used_q;
  req_t            req_q;
  logic            hit_q;
  rsp_t            rsp;
  logic [31:0]     ram_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCap) ? {27'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && paddr[2] == RegCap) begin
      cap_q <= pwdata[4:0];
    end
  end

  // Effective capacity: zero acts as one, saturate at Entries
  logic [CmpW-1:0] cap_eff;
  always_comb begin
    cap_eff = CmpW'(cap_q);
    if (cap_q == 5'd0) cap_eff = CmpW'(1);
    if (cap_eff > CmpW'(Entries)) cap_eff = CmpW'(Entries);
  end

  // Tag match, free search and oldest search over the flip-flop rows
  logic            hit;
  logic [IdxW-1:0] hit_idx, free_idx, old_idx;
  logic            free_any;
  logic [IdxW-1:0] old_age;
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
    old_idx = '0; old_age = '0;
    for (int j = Entries - 1; j >= 0; j--) begin
      if (valid_q[j] && key_q[j] == req_q.key) begin
        hit = 1'b1; hit_idx = IdxW'(j);
      end
      if (!valid_q[j]) begin
        free_any = 1'b1; free_idx = IdxW'(j);
      end
    end
    for (int j = 0; j < Entries; j++) begin
      if (valid_q[j] && age_q[j] == IdxW'(used_q - 1'b1)) begin
        old_idx = IdxW'(j); old_age = age_q[j];
      end
    end
  end

  logic fill;
  assign fill = free_any && (CmpW'(used_q) < cap_eff);

  logic            accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Capture request
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
  end

  // Decide slot and update tags and ages in the match cycle
  logic            do_upd;
  logic [IdxW-1:0] tgt;
  logic [IdxW-1:0] tgt_age;
  logic            is_fill;
  always_comb begin
    is_fill = 1'b0;
    if (hit) begin
      tgt = hit_idx; tgt_age = age_q[hit_idx];
    end else if (fill) begin
      tgt = free_idx; tgt_age = IdxW'(used_q); is_fill = 1'b1;
    end else begin
      tgt = old_idx; tgt_age = old_age;
    end
    do_upd = (state_q == ST_LOOK) && (hit || req_q.op == OP_PUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int j = 0; j < Entries; j++) age_q[j] <= '0;
    end else if (do_upd) begin
      for (int j = 0; j < Entries; j++) begin
        if (IdxW'(j) == tgt) begin
          age_q[j] <= '0;
        end else if (valid_q[j] && (is_fill || age_q[j] < tgt_age)) begin
          age_q[j] <= age_q[j] + 1'b1;
        end
      end
      if (is_fill) begin
        valid_q[tgt] <= 1'b1;
        used_q       <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd && !hit) key_q[tgt] <= req_q.key;
    if (state_q == ST_LOOK) begin
      hit_q <= hit;
    end
  end

  // Value store
  lkvc_ram #(.Width(32), .Depth(Entries)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (do_upd && req_q.op == OP_PUT),
    .waddr_i(tgt),
    .wdata_i(req_q.value),
    .raddr_i(tgt),
    .rdata_o(ram_rdata)
  );

  // Build the result from the match flag and the RAM output
  always_comb begin
    rsp.found = hit_q;
    if (req_q.op == OP_PUT) rsp.read_value = PutValue;
    else if (hit_q)         rsp.read_value = ram_rdata;
    else                    rsp.read_value = MissValue;
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = rsp;
endmodule
`default_nettype wire

// ----- bench/lru_key_value_cache_top_tb.sv -----
// Testbench for the LRU key/value cache: directed and random get/put traffic checked against a predictor.
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int Entries = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_key_value_cache_top #(.Entries(Entries)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Cache shadow state
  logic [31:0] sh_key [Entries];
  logic [31:0] sh_val [Entries];
  logic        sh_vld [Entries];
  int unsigned sh_age [Entries];
  int unsigned sh_used;
  logic [4:0]  sh_cap;

  req_t req_q[$];
  rsp_t rsp_q[$];
  int   n_err = 0;
  int   n_hits = 0;
  int   n_rsp = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   hold_off = 0;
  logic in_acc = 1'b0;

  function automatic void promote(int s);
    int a;
    a = sh_age[s];
    for (int j = 0; j < Entries; j++)
      if (sh_vld[j] && j != s && sh_age[j] < a) sh_age[j]++;
    sh_age[s] = 0;
  endfunction

  // Compute the response of one request and update the shadow cache
  function automatic rsp_t lru_lookup(req_t r);
    rsp_t o;
    int hit, slot, cap;
    hit = -1;
    slot = -1;
    for (int j = 0; j < Entries; j++)
      if (hit < 0 && sh_vld[j] && sh_key[j] == r.key) hit = j;
    o.found = (hit >= 0);
    if (op_e'(r.op) == OP_GET) begin
      o.read_value = (hit >= 0) ? sh_val[hit] : MissValue;
      if (hit >= 0) promote(hit);
      return o;
    end
    o.read_value = PutValue;
    if (hit >= 0) begin
      sh_val[hit] = r.value;
      promote(hit);
      return o;
    end
    cap = (sh_cap == 0) ? 1 : (sh_cap > Entries ? Entries : sh_cap);
    if (sh_used < cap) begin
      for (int j = 0; j < Entries; j++)
        if (slot < 0 && !sh_vld[j]) slot = j;
      if (slot >= 0) begin
        for (int j = 0; j < Entries; j++) if (sh_vld[j]) sh_age[j]++;
        sh_vld[slot] = 1'b1;
        sh_key[slot] = r.key;
        sh_val[slot] = r.value;
        sh_age[slot] = 0;
        sh_used++;
        return o;
      end
    end
    for (int j = 0; j < Entries; j++)
      if (sh_vld[j] && (slot < 0 || sh_age[j] > sh_age[slot])) slot = j;
    if (slot >= 0) begin
      sh_key[slot] = r.key;
      sh_val[slot] = r.value;
      promote(slot);
    end
    return o;
  endfunction

  // Note whether the offered request was taken at this edge
  always @(posedge clk_i) begin
    in_acc <= in_valid_i && !in_stall_o;
  end

  // Drive requests from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        in_data_i  <= req_q[0];
        rsp_q.push_back(lru_lookup(req_q.pop_front()));
      end else begin
        in_valid_i <= 1'b0;
        in_data_i  <= {1'($urandom), $urandom, $urandom};
      end
    end
  end

  // Receiver stalls: count down a long hold-off first, then stall at random
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  // Check responses
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_rsp <= n_rsp + 1;
      if (rsp_q.size() == 0) begin
        $error("response with nothing expected: found=%0b read_value=%h",
               out_data_o.found, out_data_o.read_value);
        n_err <= n_err + 1;
      end else begin
        if (out_data_o.found !== rsp_q[0].found) begin
          $error("found: expected %0b actual %0b", rsp_q[0].found, out_data_o.found);
          n_err <= n_err + 1;
        end
        if (out_data_o.read_value !== rsp_q[0].read_value) begin
          $error("read_value: expected %h actual %h",
                 rsp_q[0].read_value, out_data_o.read_value);
          n_err <= n_err + 1;
        end
        n_hits <= n_hits + rsp_q[0].found;
        void'(rsp_q.pop_front());
      end
    end
  end

  task automatic drain();
    while (req_q.size() > 0 || rsp_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write the capacity register over APB and mirror it
  task automatic write_cap(logic [4:0] c);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * RegCap);
    pwdata <= {27'($urandom), c};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sh_cap = c;
  endtask

  function automatic void push(op_e op, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.op = op; r.key = k; r.value = v;
    req_q.push_back(r);
  endfunction

  // Random traffic from a small key pool so hits and evictions are common
  task automatic random_phase(int n, int pool);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(pool - 1)) ^ 32'hA5A5_0000;
      if ($urandom_range(15) == 0) k = ~k;
      push(op_e'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    for (int j = 0; j < Entries; j++) begin
      sh_key[j] = '0; sh_val[j] = '0; sh_vld[j] = 1'b0; sh_age[j] = 0;
    end
    sh_used = 0;
    sh_cap = CapReset;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme keys and values, hits, misses, update
    push(OP_GET, 32'h8000_0000, 32'h0);
    push(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_PUT, 32'h0, 32'h0);
    push(OP_GET, 32'h8000_0000, 32'h1234_5678);
    push(OP_GET, 32'h7FFF_FFFF, 32'h0);
    push(OP_GET, 32'hFFFF_FFFF, 32'h0);
    push(OP_GET, 32'h0, 32'h0);
    push(OP_GET, 32'h0000_0001, 32'h0);
    push(OP_PUT, 32'h0, 32'h5555_AAAA);
    push(OP_GET, 32'h0, 32'h0);
    // Fill the cache exactly to its full capacity
    for (int i = 0; i < 12; i++) push(OP_PUT, 32'(100 + i), 32'(i));
    drain();

    // Capacity one, then zero (treated as one)
    write_cap(5'd1);
    push(OP_PUT, 32'd7, 32'd70);
    push(OP_GET, 32'd7, 32'd0);
    push(OP_GET, 32'd100, 32'd0);
    random_phase(60, 6);
    drain();
    write_cap(5'd0);
    random_phase(60, 4);
    drain();

    // Capacity above the entry count saturates; no idling
    write_cap(5'd31);
    random_phase(200, 24);
    drain();

    // Sender mostly idle
    send_idle = 78;
    write_cap(5'd4);
    random_phase(150, 8);
    drain();

    // Receiver mostly stalling, with a long hold-off
    send_idle = 0; recv_stall = 78;
    write_cap(5'd16);
    hold_off = 60;
    random_phase(200, 20);
    drain();

    // Both sides idle sometimes
    send_idle = 12; recv_stall = 12;
    write_cap(5'd9);
    random_phase(250, 14);
    drain();

    $display("Covered %0d responses, %0d hits, capacities 0 to 31 with evictions,",
             n_rsp, n_hits);
    $display("plus sender gaps, receiver stalls and a long output hold-off.");
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
